/* hdl/sv39_pkg.sv */
// Package for the Sv39 page table mapper: transfer payload types and constants.
// No dependencies; used by the top level and its checker.
package sv39_pkg;

  localparam int unsigned VA_W = 39;
  localparam int unsigned PA_W = 56;
  localparam int unsigned PPN_W = 44;
  localparam int unsigned TABLE_FRAMES = 64;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_NO_FRAMES = 3'd1,
    ST_REMAP = 3'd2,
    ST_RANGE = 3'd3,
    ST_ABSENT = 3'd4,
    ST_SIZE_ZERO = 3'd5
  } status_t;

  localparam logic REQ_MAP = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic [1:0] CFG_ROOT = 2'd0;
  localparam logic [1:0] CFG_FIRST_FREE = 2'd1;
  localparam logic [1:0] CFG_BASE_PPN = 2'd2;

  typedef struct packed {
    logic req_type;
    logic [38:0] virt_addr;
    logic [55:0] phys_addr;
    logic [38:0] size_bytes;
    logic [7:0] perm_bits;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [63:0] leaf_entry;
    logic [26:0] pages_written;
  } rsp_t;

endpackage

/* hdl/sv39_page_table_mapper_top.sv */
// Sv39 page table mapper top level: table memory, walker sequencer, bump allocator.
// Depends on sv39_pkg.
//
// Requests arrive on req (req_valid/req_ready), one transfer per request, and each
// request returns exactly one response on rsp (rsp_valid/rsp_ready). Registers are
// written on the cfg channel (index 0 root frame, 1 first free frame, 2 table base
// page number); cfg_ready is held high, and the user must write only while no
// request is in flight, as the block does not enforce it. A lookup walks the two
// intermediate levels and the leaf before it presents its response. Per page, a map
// whose tables exist takes a start check, two intermediate reads (address, read
// latency and check state each), the leaf read, the leaf write and the step to the
// next page. Each newly allocated table frame adds 512 clearing writes, one entry
// per cycle, and the link write. After reset the block runs a clearing pass over
// all TABLE_FRAMES*512 entries, one per cycle, before it accepts its first request.
// The response sits in an output register; while the receiver stalls it holds, and
// a new request is accepted only after it has been taken.
module sv39_page_table_mapper_top (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sv39_pkg::req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output sv39_pkg::rsp_t rsp,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int unsigned TABLE_FRAMES = sv39_pkg::TABLE_FRAMES;
  localparam int unsigned FW = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
  localparam int unsigned AW = FW + 9;
  localparam int unsigned DEPTH = TABLE_FRAMES * 512;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_START, S_RD, S_WAIT, S_EVAL, S_ZERO, S_LINK, S_LEAF_WAIT,
    S_LEAF, S_NEXT, S_DONE
  } state_t;

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0] wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  state_t state;
  logic [5:0] root_frame;
  logic [43:0] base_ppn;
  logic [6:0] next_free;
  logic lookup;
  logic [38:0] va, last;
  logic [55:0] pa;
  logic [7:0] perm;
  logic level;
  logic [FW-1:0] frame;
  logic [AW:0] cnt;
  logic [AW-1:0] slot;
  logic [2:0] status;
  logic [63:0] leaf;
  logic [26:0] written;
  logic [43:0] off;
  logic [8:0] vidx;

  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE) && !rsp_valid;
  assign off = rdata[53:10] - base_ppn;
  assign vidx = level ? va[38:30] : va[29:21];

  always_comb begin
    we = 1'b0;
    waddr = slot;
    wdata = '0;
    raddr = {frame, vidx};
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        waddr = cnt[AW-1:0];
      end
      S_ZERO: begin
        we = 1'b1;
        waddr = {next_free[FW-1:0] - FW'(1), cnt[8:0]};
      end
      S_LINK: begin
        we = 1'b1;
        waddr = slot;
        wdata = {10'd0, 44'(base_ppn + 44'(frame)), 9'd0, 1'b1};
      end
      S_LEAF_WAIT: raddr = slot;
      S_LEAF: begin
        we = lookup ? 1'b0 : !rdata[0];
        wdata = {10'd0, pa[55:12], 2'd0, perm | 8'd1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      root_frame <= '0;
      base_ppn <= 44'd524288;
      next_free <= 7'd1;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          sv39_pkg::CFG_ROOT: root_frame <= cfg_data[5:0];
          sv39_pkg::CFG_FIRST_FREE: next_free <= cfg_data[6:0];
          sv39_pkg::CFG_BASE_PPN: base_ppn <= cfg_data[43:0];
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == (AW+1)'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid && req_ready) begin
            lookup <= req.req_type;
            va <= {req.virt_addr[38:12], 12'd0};
            last <= 39'(req.virt_addr + req.size_bytes - 39'd1) & ~39'hfff;
            pa <= req.phys_addr;
            perm <= req.perm_bits;
            status <= sv39_pkg::ST_OK;
            leaf <= '0;
            written <= '0;
            if (req.req_type == sv39_pkg::REQ_MAP && req.size_bytes == '0) begin
              status <= sv39_pkg::ST_SIZE_ZERO;
              state <= S_DONE;
            end else begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          level <= 1'b1;
          if (va[38]) begin
            status <= sv39_pkg::ST_RANGE;
            state <= S_DONE;
          end else if (32'(root_frame) >= TABLE_FRAMES) begin
            status <= sv39_pkg::ST_ABSENT;
            state <= S_DONE;
          end else begin
            frame <= root_frame[FW-1:0];
            state <= S_RD;
          end
        end
        S_RD: begin
          slot <= {frame, vidx};
          state <= S_WAIT;
        end
        S_WAIT: state <= S_EVAL;
        S_EVAL: begin
          if (rdata[0]) begin
            if (off >= 44'(TABLE_FRAMES)) begin
              status <= sv39_pkg::ST_ABSENT;
              state <= S_DONE;
            end else begin
              frame <= off[FW-1:0];
              state <= level ? S_RD : S_LEAF_WAIT;
              if (!level) slot <= {off[FW-1:0], va[20:12]};
              level <= 1'b0;
            end
          end else if (lookup) begin
            status <= sv39_pkg::ST_ABSENT;
            state <= S_DONE;
          end else if (32'(next_free) >= TABLE_FRAMES) begin
            status <= sv39_pkg::ST_NO_FRAMES;
            state <= S_DONE;
          end else begin
            next_free <= next_free + 7'd1;
            cnt <= '0;
            state <= S_ZERO;
          end
        end
        S_ZERO: begin
          cnt <= cnt + 1'b1;
          if (cnt[8:0] == 9'h1ff) begin
            frame <= next_free[FW-1:0] - FW'(1);
            state <= S_LINK;
          end
        end
        S_LINK: begin
          if (level) begin
            level <= 1'b0;
            state <= S_RD;
          end else begin
            slot <= {frame, va[20:12]};
            state <= S_LEAF_WAIT;
          end
        end
        S_LEAF_WAIT: state <= S_LEAF;
        S_LEAF: begin
          if (lookup) begin
            if (rdata[0]) leaf <= rdata;
            else status <= sv39_pkg::ST_ABSENT;
            state <= S_DONE;
          end else if (rdata[0]) begin
            status <= sv39_pkg::ST_REMAP;
            state <= S_DONE;
          end else begin
            written <= written + 27'd1;
            state <= (va == last) ? S_DONE : S_NEXT;
          end
        end
        S_NEXT: begin
          va <= va + 39'h1000;
          pa <= pa + 56'h1000;
          state <= S_START;
        end
        S_DONE: begin
          rsp_valid <= 1'b1;
          rsp.status <= status;
          rsp.leaf_entry <= leaf;
          rsp.pages_written <= written;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/sv39_checker.sv */
// Port checker for the Sv39 page table mapper top level.
// Depends on sv39_pkg; bound to sv39_page_table_mapper_top.
module sv39_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input sv39_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp)) else $error("response dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("request accepted while response waits");
  a_one_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !rsp_valid) else $error("response too early");
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status <= 3'd5) else $error("bad status");
  a_lookup_written: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.leaf_entry != '0 |-> rsp.pages_written == '0)
    else $error("leaf with pages written");

endmodule

bind sv39_page_table_mapper_top sv39_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
  .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
